// ----- rtl/core/imsu_pkg.sv -----
package imsu_pkg;

   localparam int KIND_W = 2;
   localparam int COORD_IN_W = 6;
   localparam int COORD_SPAN = 2 ** COORD_IN_W;
   localparam int ENTRY_IDX_W = 4;
   localparam int ENTRY_W = 17;
   localparam int RANDOM_W = 16;
   localparam int ENTRY_COUNT = 10;
   localparam int ENTRY_MINUS_BASE = 5;
   localparam int SIDE_DEFAULT = 64;
   localparam logic [ENTRY_W-1:0] ALWAYS_VALUE = 17'h10000;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD = 2'd0,
      KIND_ENTRY = 2'd1,
      KIND_UPDATE = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_NEAR,
      ST_READ_FAR,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic ready;
      logic clear;
      logic rd_near;
      logic rd_far;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic req_valid;
      kind_type req_kind;
      kind_type kind;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/core/imsu_if.sv -----
interface imsu_req_if import imsu_pkg::*;;
   logic valid;
   logic ready;
   logic [KIND_W-1:0] kind;
   logic [COORD_IN_W-1:0] row;
   logic [COORD_IN_W-1:0] col;
   logic spin_in;
   logic [ENTRY_IDX_W-1:0] entry_index;
   logic [ENTRY_W-1:0] entry_value;
   logic [RANDOM_W-1:0] random_value;

   modport source (
      output valid, kind, row, col, spin_in, entry_index, entry_value, random_value,
      input ready
   );
   modport sink (
      input valid, kind, row, col, spin_in, entry_index, entry_value, random_value,
      output ready
   );
endinterface

interface imsu_rsp_if;
   logic valid;
   logic ready;
   logic spin_out;
   logic flipped;

   modport source (output valid, spin_out, flipped, input ready);
   modport sink (input valid, spin_out, flipped, output ready);
endinterface

// ----- rtl/core/imsu_ctrl.sv -----
module imsu_ctrl import imsu_pkg::*; (
   input logic clock,
   input logic reset,
   input status_type status,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (status.req_valid) begin
               state_in = (status.req_kind == KIND_ENTRY) ? ST_EXEC : ST_READ_NEAR;
            end
         end
         ST_READ_NEAR: begin
            state_in = (status.kind == KIND_UPDATE) ? ST_READ_FAR : ST_EXEC;
         end
         ST_READ_FAR: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: cmd.ready = 1'b1;
         ST_READ_NEAR: cmd.rd_near = 1'b1;
         ST_READ_FAR: cmd.rd_far = 1'b1;
         ST_EXEC: cmd.exec = status.out_free;
         default: cmd = '0;
      endcase
   end

   // An update must have fetched the far neighbour row before it completes.
   a_update_reads_far: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && status.kind == KIND_UPDATE && $past(state_ff) != ST_EXEC)
      |-> $past(state_ff) == ST_READ_FAR)
      else $error("update reached execute without the far row read");

   a_entry_direct: assert property (@(posedge clock) disable iff (reset)
      (cmd.ready && status.req_valid && status.req_kind == KIND_ENTRY)
      |=> state_ff == ST_EXEC)
      else $error("table write beat did not go straight to execute");

endmodule

// ----- rtl/core/imsu_datapath.sv -----
module imsu_datapath import imsu_pkg::*; #(
   parameter int SIDE = SIDE_DEFAULT
) (
   input logic clock,
   input logic reset,
   input cmd_type cmd,
   output status_type status,
   imsu_req_if.sink req_if,
   imsu_rsp_if.source rsp_if
);

   localparam int CW = $clog2(SIDE);

   typedef logic [CW-1:0] coord_type;

   function automatic logic [COORD_SPAN*CW-1:0] build_coord_map();
      logic [COORD_SPAN*CW-1:0] m;
      int unsigned c;
      m = '0;
      c = 0;
      for (int i = 0; i < COORD_SPAN; i++) begin
         m[i*CW +: CW] = CW'(c);
         c = (c + 1 == SIDE) ? 0 : c + 1;
      end
      return m;
   endfunction

   localparam logic [COORD_SPAN*CW-1:0] COORD_MAP = build_coord_map();

   kind_type kind_ff;
   logic [COORD_IN_W-1:0] row_ff;
   logic [COORD_IN_W-1:0] col_ff;
   logic spin_ff;
   logic [ENTRY_IDX_W-1:0] idx_ff;
   logic [ENTRY_W-1:0] val_ff;
   logic [RANDOM_W-1:0] rnd_ff;

   logic [SIDE-1:0] lattice_mem [SIDE];
   logic [SIDE-1:0] row_a_ff;
   logic [SIDE-1:0] row_b_ff;
   logic up_bit_ff;
   coord_type clr_row_ff;
   coord_type clr_row_in;

   logic [ENTRY_W-1:0] accept_ff [ENTRY_COUNT];

   logic rsp_valid_ff;
   logic rsp_spin_ff;
   logic rsp_flipped_ff;

   coord_type row_c, col_c, up_c, down_c, left_c, right_c;
   logic capture;
   logic out_free;
   logic centre_bit, left_bit, right_bit, down_bit;
   logic [2:0] ups;
   logic [ENTRY_IDX_W-1:0] sel;
   logic flip;
   logic [SIDE-1:0] new_row;
   logic spin_new;
   logic flip_new;
   logic row_wr;
   logic wr_en;
   coord_type wr_addr;
   logic [SIDE-1:0] wr_data;

   assign capture = cmd.ready && req_if.valid;
   assign req_if.ready = cmd.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign status.clear_done = (clr_row_ff == CW'(SIDE - 1));
   assign status.req_valid = req_if.valid;
   assign status.req_kind = kind_type'(req_if.kind);
   assign status.kind = kind_ff;
   assign status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (capture) begin
         kind_ff <= kind_type'(req_if.kind);
         row_ff <= req_if.row;
         col_ff <= req_if.col;
         spin_ff <= req_if.spin_in;
         idx_ff <= req_if.entry_index;
         val_ff <= req_if.entry_value;
         rnd_ff <= req_if.random_value;
      end
   end

   always_comb begin
      row_c = COORD_MAP[row_ff*CW +: CW];
      col_c = COORD_MAP[col_ff*CW +: CW];
      up_c = (row_c == '0) ? CW'(SIDE - 1) : row_c - CW'(1);
      down_c = (row_c == CW'(SIDE - 1)) ? '0 : row_c + CW'(1);
      left_c = (col_c == '0) ? CW'(SIDE - 1) : col_c - CW'(1);
      right_c = (col_c == CW'(SIDE - 1)) ? '0 : col_c + CW'(1);
   end

   assign clr_row_in = status.clear_done ? clr_row_ff : clr_row_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
      end else if (cmd.clear) begin
         clr_row_ff <= clr_row_in;
      end
   end

   always_comb begin
      centre_bit = row_a_ff[col_c];
      left_bit = row_a_ff[left_c];
      right_bit = row_a_ff[right_c];
      down_bit = row_b_ff[col_c];
      ups = 3'(left_bit) + 3'(right_bit) + 3'(up_bit_ff) + 3'(down_bit);
      sel = centre_bit ? {1'b0, ups} : ENTRY_IDX_W'(ENTRY_MINUS_BASE) + {1'b0, ups};
      flip = ({1'b0, rnd_ff} < accept_ff[sel]);
      new_row = row_a_ff;
      spin_new = 1'b0;
      flip_new = 1'b0;
      row_wr = 1'b0;
      unique case (kind_ff)
         KIND_LOAD: begin
            new_row[col_c] = spin_ff;
            spin_new = spin_ff;
            row_wr = 1'b1;
         end
         KIND_ENTRY: begin
            spin_new = 1'b0;
         end
         KIND_UPDATE: begin
            new_row[col_c] = centre_bit ^ flip;
            spin_new = centre_bit ^ flip;
            flip_new = flip;
            row_wr = flip;
         end
         KIND_READ: begin
            spin_new = centre_bit;
         end
         default: spin_new = 1'b0;
      endcase
   end

   assign wr_en = cmd.clear || (cmd.exec && row_wr);
   assign wr_addr = cmd.clear ? clr_row_ff : row_c;
   assign wr_data = cmd.clear ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) lattice_mem[wr_addr] <= wr_data;
      if (cmd.rd_near) begin
         row_a_ff <= lattice_mem[row_c];
         row_b_ff <= lattice_mem[up_c];
      end else if (cmd.rd_far) begin
         row_b_ff <= lattice_mem[down_c];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_far) up_bit_ff <= row_b_ff[col_c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRY_COUNT; i++) accept_ff[i] <= '0;
      end else if (cmd.exec && kind_ff == KIND_ENTRY
                   && idx_ff < ENTRY_IDX_W'(ENTRY_COUNT)) begin
         accept_ff[idx_ff] <= (val_ff > ALWAYS_VALUE) ? ALWAYS_VALUE : val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_spin_ff <= spin_new;
         rsp_flipped_ff <= flip_new;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.spin_out = rsp_spin_ff;
   assign rsp_if.flipped = rsp_flipped_ff;

   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !(cmd.rd_near || cmd.rd_far))
      else $error("lattice written while its rows are being fetched");

   a_result_follows_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff)
      else $error("completed item left no result beat");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !capture)
      else $error("request beat taken during the clearing pass");

endmodule

// ----- rtl/core/ising_metropolis_site_update.sv -----
// A table write goes from its request beat straight to execute; a load or read first
// fetches its rows, and an update fetches the far row too. Execute waits for a free result
// register, and a request beat is taken only in idle. The lattice memory is row-wide
// with two registered read ports: an update fetches three rows, then writes back the
// row if the spin flips and returns to idle. After reset the lattice is cleared one row per cycle,
// before any request beat is taken; the acceptance table flip-flops clear at once.
module ising_metropolis_site_update import imsu_pkg::*; #(
   parameter int SIDE = SIDE_DEFAULT
) (
   input logic clock,
   input logic reset,
   imsu_req_if.sink req_if,
   imsu_rsp_if.source rsp_if
);

   cmd_type cmd;
   status_type status;

   imsu_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .status(status),
      .cmd(cmd)
   );

   imsu_datapath #(.SIDE(SIDE)) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

endmodule
